// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Opcodes, status codes, result limits and the status struct of the
// iterative units.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DIV_ZERO = 1'b1;

  // result limits, 33 bits so they extend cleanly into wider magnitudes
  localparam logic [32:0] RES_NEG_LIMIT = 33'h0_8000_0000;
  localparam logic [32:0] RES_POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [32:0] RES_DEN_MAX   = 33'h0_3FFF_FFFF;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// ===== hdl/rational_arith_unit_core.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit_core: fraction add/sub/mul/div with gcd reduction
// Shared multiplier forms the cross products, then a binary gcd and a
// bit-serial divider reduce numerator and denominator to lowest terms.
// ----------------------------------------------------------------------------
// Sequence: three multiply steps, a combine step, the gcd loop, two divisions
//   (numerator, then denominator) and the output step. Zero or divide-by-zero
//   results skip the gcd and divider and go straight to the output step.
// Throughput: one request at a time; the next is taken once the current one
//   has reached the output register, which is set by the gcd and divider loops.
// Reset: synchronous, clears the sequencer, the gcd and divider start, busy and
//   done flags and output valid; no other state.
`default_nettype none

module rational_arith_unit_core #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      req_type,
  input  wire logic signed [OPERAND_WIDTH-1:0] lhs_num,
  input  wire logic [OPERAND_WIDTH-2:0]        lhs_den,
  input  wire logic signed [OPERAND_WIDTH-1:0] rhs_num,
  input  wire logic [OPERAND_WIDTH-2:0]        rhs_den,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [31:0]                   res_num,
  output logic [29:0]                          res_den,
  output logic                                 status
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * OPERAND_WIDTH;
  localparam int EW = (MW > 33) ? MW : 33;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_COMB,
    S_GCD,
    S_DIV_NUM,
    S_DIV_DEN,
    S_FIN
  } state_t;

  state_t          state;
  rau_pkg::op_t    op;
  logic            sa;
  logic            sc;
  logic [W-1:0]    ma;
  logic [W-1:0]    mc;
  logic [W-1:0]    b;
  logic [W-1:0]    d;
  logic [MW-1:0]   t1;
  logic [MW-1:0]   t2;
  logic [MW-1:0]   t3;
  logic [MW-1:0]   mag;
  logic [MW-1:0]   den;
  logic            neg;
  logic [MW-1:0]   g;
  logic [MW-1:0]   qnum;
  logic            gcd_start;
  logic            div_start;
  logic [31:0]     fin_num;
  logic [29:0]     fin_den;
  logic            fin_stat;

  // operand decode
  logic [W-1:0]    lraw;
  logic [W-1:0]    rraw;
  logic [W-1:0]    lmag;
  logic [W-1:0]    rmag;

  assign lraw = lhs_num;
  assign rraw = rhs_num;
  assign lmag = lraw[W-1] ? (~lraw + 1'b1) : lraw;
  assign rmag = rraw[W-1] ? (~rraw + 1'b1) : rraw;

  // shared multiplier
  logic [W-1:0]    mul_a;
  logic [W-1:0]    mul_b;
  logic [MW-1:0]   mul_p;

  always_comb begin
    unique case (state)
      S_MUL1: begin
        mul_a = ma;
        mul_b = (op == rau_pkg::OP_MUL) ? mc : d;
      end
      S_MUL2: begin
        mul_a = mc;
        mul_b = b;
      end
      S_MUL3: begin
        mul_a = b;
        mul_b = d;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

  // combine cross products
  logic            s2;
  logic [MW-1:0]   c_mag;
  logic [MW-1:0]   c_den;
  logic            c_neg;

  always_comb begin
    s2 = (op == rau_pkg::OP_SUB) ? !sc : sc;
    unique case (op)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
        c_den = t3;
        priority if (sa == s2) begin
          c_mag = t1 + t2;
          c_neg = sa;
        end else if (t1 >= t2) begin
          c_mag = t1 - t2;
          c_neg = sa;
        end else begin
          c_mag = t2 - t1;
          c_neg = s2;
        end
      end
      rau_pkg::OP_MUL: begin
        c_mag = t1;
        c_den = t3;
        c_neg = sa ^ sc;
      end
      default: begin
        c_mag = t1;
        c_den = t2;
        c_neg = sa ^ sc;
      end
    endcase
  end

  // iterative units
  rau_pkg::unit_stat_t gcd_stat;
  rau_pkg::unit_stat_t div_stat;
  logic [MW-1:0]       gcd_g;
  logic [MW-1:0]       div_q;
  logic [MW-1:0]       div_dvd;

  assign div_dvd = (state == S_DIV_DEN) ? den : mag;

  rau_gcd #(
    .WIDTH (MW)
  ) u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a_in  (mag),
    .b_in  (den),
    .g     (gcd_g),
    .stat  (gcd_stat)
  );

  rau_div #(
    .WIDTH (MW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (g),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // saturation of the reduced terms
  logic [EW-1:0]   num_x;
  logic [EW-1:0]   den_x;
  logic [31:0]     sat_mag;
  logic [29:0]     sat_den;

  always_comb begin
    num_x = EW'(qnum);
    den_x = EW'(div_q);
    priority if (neg && num_x > EW'(rau_pkg::RES_NEG_LIMIT)) begin
      sat_mag = rau_pkg::RES_NEG_LIMIT[31:0];
    end else if (!neg && num_x > EW'(rau_pkg::RES_POS_LIMIT)) begin
      sat_mag = rau_pkg::RES_POS_LIMIT[31:0];
    end else begin
      sat_mag = num_x[31:0];
    end
    sat_den = (den_x > EW'(rau_pkg::RES_DEN_MAX)) ? rau_pkg::RES_DEN_MAX[29:0]
                                                   : den_x[29:0];
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    gcd_start <= 1'b0;
    div_start <= 1'b0;
    if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op    <= rau_pkg::op_t'(req_type);
          sa    <= lraw[W-1];
          sc    <= rraw[W-1];
          ma    <= lmag;
          mc    <= rmag;
          b     <= (lhs_den == '0) ? W'(1) : {1'b0, lhs_den};
          d     <= (rhs_den == '0) ? W'(1) : {1'b0, rhs_den};
          state <= S_MUL1;
        end
      end
      S_MUL1: begin
        t1    <= mul_p;
        state <= S_MUL2;
      end
      S_MUL2: begin
        t2    <= mul_p;
        state <= S_MUL3;
      end
      S_MUL3: begin
        t3    <= mul_p;
        state <= S_COMB;
      end
      S_COMB: begin
        mag <= c_mag;
        den <= c_den;
        neg <= c_neg;
        priority if (op == rau_pkg::OP_DIV && mc == '0) begin
          fin_num  <= '0;
          fin_den  <= 30'd1;
          fin_stat <= rau_pkg::STATUS_DIV_ZERO;
          state    <= S_FIN;
        end else if (c_mag == '0) begin
          fin_num  <= '0;
          fin_den  <= 30'd1;
          fin_stat <= rau_pkg::STATUS_OK;
          state    <= S_FIN;
        end else begin
          gcd_start <= 1'b1;
          state     <= S_GCD;
        end
      end
      S_GCD: begin
        if (gcd_stat.done) begin
          g         <= gcd_g;
          div_start <= 1'b1;
          state     <= S_DIV_NUM;
        end
      end
      S_DIV_NUM: begin
        if (div_stat.done) begin
          qnum      <= div_q;
          div_start <= 1'b1;
          state     <= S_DIV_DEN;
        end
      end
      S_DIV_DEN: begin
        if (div_stat.done) begin
          fin_num  <= neg ? (32'd0 - sat_mag) : sat_mag;
          fin_den  <= sat_den;
          fin_stat <= rau_pkg::STATUS_OK;
          state    <= S_FIN;
        end
      end
      S_FIN: begin
        // output register free or being emptied this cycle
        if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          res_num   <= fin_num;
          res_den   <= fin_den;
          status    <= fin_stat;
          state     <= S_IDLE;
        end
      end
      default: begin
        state <= S_IDLE;
      end
    endcase
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      gcd_start <= 1'b0;
      div_start <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> res_den != '0)
    else $error("zero result denominator");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == rau_pkg::STATUS_DIV_ZERO) |-> (res_num == '0 && res_den == 30'd1))
    else $error("divide-by-zero result not 0/1");
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside final step");
  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV_NUM || state == S_DIV_DEN))
    else $error("divider finished outside a divide step");
  assert property (@(posedge clk) disable iff (rst) gcd_stat.done |-> state == S_GCD)
    else $error("gcd finished outside gcd step");

endmodule

`default_nettype wire

// ===== hdl/rau_gcd.sv =====
// ----------------------------------------------------------------------------
// rau_gcd: iterative binary greatest common divisor
// One halving or one subtraction per cycle; common factors of two are
// counted and restored by a shift when one operand reaches zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_gcd #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] a_in,
  input  wire logic [WIDTH-1:0] b_in,
  output logic [WIDTH-1:0]      g,
  output rau_pkg::unit_stat_t   stat
);

  localparam int KW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;
  logic [KW-1:0]    k;

  always_ff @(posedge clk) begin
    stat.done <= 1'b0;
    if (start) begin
      a         <= a_in;
      b         <= b_in;
      k         <= '0;
      stat.busy <= 1'b1;
    end else if (stat.busy) begin
      priority if (a == '0) begin
        g         <= b << k;
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end else if (b == '0) begin
        g         <= a << k;
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end else if (!a[0] && !b[0]) begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + 1'b1;
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a >= b) begin
        a <= a - b;
      end else begin
        b <= b - a;
      end
    end
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) stat.done |-> !stat.busy)
    else $error("gcd done while still busy");
  assert property (@(posedge clk) disable iff (rst) stat.done |-> g != '0)
    else $error("gcd result is zero");
  assert property (@(posedge clk) disable iff (rst)
    (stat.busy && !start) |=> ($past(k) == k) || ($past(k) + 1'b1 == k))
    else $error("gcd shift count jumped");

endmodule

`default_nettype wire

// ===== hdl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div: restoring divider, one quotient bit per cycle
// Quotient builds up in the dividend shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic [WIDTH-1:0]      quotient,
  output rau_pkg::unit_stat_t   stat
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [WIDTH:0]   trial;
  logic             ge;

  assign trial = {rem, quotient[WIDTH-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    stat.done <= 1'b0;
    if (start) begin
      quotient  <= dividend;
      dvs       <= divisor;
      rem       <= '0;
      cnt       <= CW'(WIDTH - 1);
      stat.busy <= 1'b1;
    end else if (stat.busy) begin
      rem      <= ge ? WIDTH'(trial - {1'b0, dvs}) : trial[WIDTH-1:0];
      quotient <= {quotient[WIDTH-2:0], ge};
      cnt      <= cnt - 1'b1;
      if (cnt == '0) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end
  end

  // the divisor is always a gcd of the dividend, so nothing is left over
  assert property (@(posedge clk) disable iff (rst) stat.done |-> rem == '0)
    else $error("inexact division");
  assert property (@(posedge clk) disable iff (rst) stat.busy |-> dvs != '0)
    else $error("division by zero in divider");
  assert property (@(posedge clk) disable iff (rst) stat.done |-> !stat.busy)
    else $error("divider done while busy");

endmodule

`default_nettype wire

// ===== dv/tb_rational_arith_unit_core.sv =====
// ----------------------------------------------------------------------------
// tb_rational_arith_unit_core: self-checking bench for the fraction unit
// Drives add/sub/mul/div requests on two fractions and compares every
// reduced result, in order, against a fraction model kept in the bench.
// Directed corner cases run first, then random requests. Both sides of the
// unit see random idle bursts, except near the end of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rational_arith_unit_core;

  localparam int OPW         = 16;
  localparam int N_RANDOM    = 630;
  localparam int CALM_TAIL   = 60;
  localparam int DRAIN_WAIT  = 300;
  localparam int CYCLE_LIMIT = 800000;

  typedef struct {
    rau_pkg::op_t          op;
    logic signed [OPW-1:0] lhs_num;
    logic [OPW-2:0]        lhs_den;
    logic signed [OPW-1:0] rhs_num;
    logic [OPW-2:0]        rhs_den;
  } frac_req_t;

  typedef struct {
    logic signed [31:0] num;
    logic [29:0]        den;
    logic               status;
  } frac_res_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [1:0]            req_type  = '0;
  logic signed [OPW-1:0] lhs_num   = '0;
  logic [OPW-2:0]        lhs_den   = '0;
  logic signed [OPW-1:0] rhs_num   = '0;
  logic [OPW-2:0]        rhs_den   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [31:0]    res_num;
  logic [29:0]           res_den;
  logic                  status;

  frac_req_t pending_reqs[$];
  frac_res_t reduced_q[$];
  frac_req_t next_req;
  frac_res_t want;

  int  total_reqs  = 0;
  int  issued      = 0;
  int  mismatches  = 0;
  int  cycle_count = 0;
  int  in_gap      = 0;
  int  stall_left  = 0;
  bit  req_fired   = 1'b0;
  wire calm = (issued + CALM_TAIL >= total_reqs);

  rational_arith_unit_core #(.OPERAND_WIDTH(OPW)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .lhs_num   (lhs_num),
    .lhs_den   (lhs_den),
    .rhs_num   (rhs_num),
    .rhs_den   (rhs_den),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_num   (res_num),
    .res_den   (res_den),
    .status    (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exact fraction arithmetic, reduced by gcd, saturated to the result limits, sign kept in the numerator
  function automatic frac_res_t fraction_result(rau_pkg::op_t op,
                                                logic signed [OPW-1:0] ln,
                                                logic [OPW-2:0] ld,
                                                logic signed [OPW-1:0] rn,
                                                logic [OPW-2:0] rd);
    frac_res_t  res;
    logic       sa, sc, s2, neg;
    logic [63:0] ma, mc, b, d, t1, t2, mag, den, x, y, r;
    sa = ln[OPW-1];
    sc = rn[OPW-1];
    ma = sa ? (~{{(64-OPW){1'b1}}, ln} + 64'd1) : {{(64-OPW){1'b0}}, ln};
    mc = sc ? (~{{(64-OPW){1'b1}}, rn} + 64'd1) : {{(64-OPW){1'b0}}, rn};
    b  = (ld == '0) ? 64'd1 : {{(65-OPW){1'b0}}, ld};
    d  = (rd == '0) ? 64'd1 : {{(65-OPW){1'b0}}, rd};
    res.num    = '0;
    res.den    = 30'd1;
    res.status = rau_pkg::STATUS_OK;
    case (op)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
        t1 = ma * d;
        t2 = mc * b;
        s2 = (op == rau_pkg::OP_SUB) ? !sc : sc;
        if (sa == s2) begin
          mag = t1 + t2;
          neg = sa;
        end else if (t1 >= t2) begin
          mag = t1 - t2;
          neg = sa;
        end else begin
          mag = t2 - t1;
          neg = s2;
        end
        den = b * d;
      end
      rau_pkg::OP_MUL: begin
        mag = ma * mc;
        neg = sa != sc;
        den = b * d;
      end
      default: begin
        if (mc == 64'd0) begin
          res.status = rau_pkg::STATUS_DIV_ZERO;
          return res;
        end
        mag = ma * d;
        neg = sa != sc;
        den = b * mc;
      end
    endcase
    if (mag == 64'd0) return res;
    x = mag;
    y = den;
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    mag = mag / x;
    den = den / x;
    if (neg && mag > 64'(rau_pkg::RES_NEG_LIMIT)) mag = 64'(rau_pkg::RES_NEG_LIMIT);
    if (!neg && mag > 64'(rau_pkg::RES_POS_LIMIT)) mag = 64'(rau_pkg::RES_POS_LIMIT);
    if (den > 64'(rau_pkg::RES_DEN_MAX)) den = 64'(rau_pkg::RES_DEN_MAX);
    res.num = neg ? 32'(64'd0 - mag) : mag[31:0];
    res.den = den[29:0];
    return res;
  endfunction

  function automatic logic signed [OPW-1:0] pick_num();
    case ($urandom_range(0, 7))
      0: return OPW'(int'($urandom_range(0, 40)) - 20);
      1: case ($urandom_range(0, 4))
           0: return OPW'(-(2 ** (OPW - 1)));
           1: return OPW'(2 ** (OPW - 1) - 1);
           2: return '0;
           3: return OPW'(1);
           default: return '1;
         endcase
      2: return OPW'(int'($urandom_range(0, 2000)) - 1000);
      default: return OPW'($urandom());
    endcase
  endfunction

  function automatic logic [OPW-2:0] pick_den();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return (OPW - 1)'(1);
      2: return '1;
      3: return (OPW - 1)'($urandom_range(1, 30));
      default: return (OPW - 1)'($urandom());
    endcase
  endfunction

  task automatic add_req(rau_pkg::op_t op, int ln, int ld, int rn, int rd);
    frac_req_t q;
    q.op      = op;
    q.lhs_num = OPW'(ln);
    q.lhs_den = (OPW - 1)'(ld);
    q.rhs_num = OPW'(rn);
    q.rhs_den = (OPW - 1)'(rd);
    pending_reqs.push_back(q);
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] exp_val);
    mismatches++;
    $display("MISMATCH %s: got 0x%0h, exp 0x%0h (cycle %0d)", field, got, exp_val,
             cycle_count);
  endtask

  // request driver, changes inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_fired) begin
      // held until taken
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      next_req = pending_reqs.pop_front();
      req_type <= next_req.op;
      lhs_num  <= next_req.lhs_num;
      lhs_den  <= next_req.lhs_den;
      rhs_num  <= next_req.rhs_num;
      rhs_den  <= next_req.rhs_den;
      in_valid <= 1'b1;
      issued++;
      if (!calm && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 10);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result back-pressure in bursts
  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: takes requests and results on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      req_fired = 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (reduced_q.size() == 0) begin
          report_mismatch("result with no request pending", 64'(res_num), 64'd0);
        end else begin
          want = reduced_q.pop_front();
          if (res_num !== want.num) report_mismatch("res_num", 64'(res_num), 64'(want.num));
          if (res_den !== want.den) report_mismatch("res_den", 64'(res_den), 64'(want.den));
          if (status !== want.status)
            report_mismatch("status", 64'(status), 64'(want.status));
        end
      end
      req_fired = in_valid && (in_stall === 1'b0);
      if (req_fired)
        reduced_q.push_back(fraction_result(rau_pkg::op_t'(req_type), lhs_num, lhs_den,
                                            rhs_num, rhs_den));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // directed corners: extremes, zero denominators, zero results, div by zero
    add_req(rau_pkg::OP_ADD, 0, 0, 0, 0);
    add_req(rau_pkg::OP_ADD, 32767, 1, 32767, 1);
    add_req(rau_pkg::OP_ADD, -32768, 32767, -32768, 32766);
    add_req(rau_pkg::OP_SUB, 1, 2, 1, 2);
    add_req(rau_pkg::OP_SUB, -32768, 1, 32767, 1);
    add_req(rau_pkg::OP_SUB, 32767, 32767, -32768, 1);
    add_req(rau_pkg::OP_MUL, -32768, 0, -32768, 0);
    add_req(rau_pkg::OP_MUL, 0, 5, -7, 3);
    add_req(rau_pkg::OP_MUL, 32767, 32767, 32767, 32767);
    add_req(rau_pkg::OP_MUL, -1, 32767, 1, 32767);
    add_req(rau_pkg::OP_DIV, 3, 4, 0, 7);
    add_req(rau_pkg::OP_DIV, 0, 0, 0, 0);
    add_req(rau_pkg::OP_DIV, -32768, 1, 1, 32767);
    add_req(rau_pkg::OP_DIV, 5, 1, -32768, 32767);
    add_req(rau_pkg::OP_DIV, 0, 3, 5, 7);
    add_req(rau_pkg::OP_ADD, 6, 4, 0, 0);
    add_req(rau_pkg::OP_SUB, 7, 0, -3, 0);
    add_req(rau_pkg::OP_DIV, 32767, 32767, -1, 1);
    add_req(rau_pkg::OP_MUL, -5, 10, 4, 6);
    add_req(rau_pkg::OP_ADD, 32767, 0, -32768, 0);
    repeat (N_RANDOM)
      add_req(rau_pkg::op_t'($urandom_range(0, 3)), int'(pick_num()), int'(pick_den()),
              int'(pick_num()), int'(pick_den()));
    total_reqs = pending_reqs.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (issued < total_reqs || in_valid) @(posedge clk);
    while (reduced_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
